/* rtl/tei_pkg.sv */
// ----------------------------------------------------------------------------
// tei_pkg: shared types and constants of the tree ensemble inference unit
// sizes of the node and feature stores, command and result beats, fsm states
// ----------------------------------------------------------------------------
package tei_pkg;

  // store sizes
  localparam int unsigned MAX_TREES      = 64;
  localparam int unsigned NODES_PER_TREE = 128;
  localparam int unsigned NUM_FEATURES   = 32;
  localparam int unsigned MAX_WALK_DEPTH = 8;

  localparam int unsigned TREE_W  = $clog2(MAX_TREES);
  localparam int unsigned NODE_W  = $clog2(NODES_PER_TREE);
  localparam int unsigned FEAT_W  = $clog2(NUM_FEATURES);
  localparam int unsigned ADDR_W  = TREE_W + NODE_W;
  localparam int unsigned DEPTH_W = $clog2(MAX_WALK_DEPTH + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_TREES + 1);
  localparam int unsigned STORE_SIZE = MAX_TREES * NODES_PER_TREE;

  // q16.16 values, unsigned q1.16 rate, wide accumulator
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LR_W   = 17;
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned PROD_W = VAL_W + LR_W + 1;
  localparam int unsigned SUM_W  = VAL_W + CNT_W + 2;
  localparam logic [LR_W-1:0] LR_ONE = LR_W'(65536);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_BASE_VALUE    = 2'd1,
    CFG_CLIP_LIMIT    = 2'd2,
    CFG_TREE_COUNT    = 2'd3
  } tei_cfg_e;

  localparam logic [LR_W-1:0]       LR_RESET    = LR_W'(6554);
  localparam logic [LIM_W-1:0]      LIM_RESET   = LIM_W'(655360000);

  // actions
  typedef enum logic [1:0] {
    ACT_WRITE_NODE    = 2'd0,
    ACT_WRITE_FEATURE = 2'd1,
    ACT_EVALUATE      = 2'd2,
    ACT_NONE          = 2'd3
  } tei_action_e;

  // command beat
  typedef struct packed {
    logic [1:0]              action;
    logic [TREE_W-1:0]       tree_slot;
    logic [NODE_W-1:0]       node_slot;
    logic [FEAT_W-1:0]       split_feature;
    logic                    leaf_flag;
    logic signed [VAL_W-1:0] threshold;
    logic signed [VAL_W-1:0] node_value;
    logic [NODE_W-1:0]       left_node;
    logic [NODE_W-1:0]       right_node;
    logic [FEAT_W-1:0]       feature_slot;
    logic signed [VAL_W-1:0] feature_value;
  } tei_cmd_t;

  // result beat
  typedef struct packed {
    logic signed [VAL_W-1:0] prediction;
    logic                    clipped;
  } tei_result_t;

  // one stored node
  typedef struct packed {
    logic [FEAT_W-1:0]       split_feature;
    logic                    leaf_flag;
    logic [NODE_W-1:0]       left_node;
    logic [NODE_W-1:0]       right_node;
    logic signed [VAL_W-1:0] threshold;
    logic signed [VAL_W-1:0] node_value;
  } tei_node_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLIP,
    ST_MULT,
    ST_ACCUM,
    ST_FINAL
  } tei_state_e;

endpackage

/* rtl/tree_ensemble_inference_unit.sv */
// ----------------------------------------------------------------------------
// tree_ensemble_inference_unit: boosted regression tree ensemble evaluator
// node and feature stores, a tree walker and one shared clip, multiply and
// accumulate path under a small sequencer
// ----------------------------------------------------------------------------
// A node or feature write is taken without a busy phase: busy stays low. An
// evaluation keeps busy high while a sequencer walks the trees one after the
// other, reading one node of the node memory per cycle (single read port,
// registered read data). Each tree walks one to MAX_WALK_DEPTH+1 node
// reads, then passes through the clip, multiply and accumulate states, and
// after the last tree the final clip state builds the result; when no tree
// is in use the sequencer goes straight to the final clip. The result is
// shown for a single cycle with result_valid_o in the cycle after busy falls
// and must be taken then: there is no way to hold it. Configuration may only
// be written while busy is low. Nodes and features must be written before
// they are used.
// ----------------------------------------------------------------------------
module tree_ensemble_inference_unit
  import tei_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tei_cmd_t             cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_wdata_i,
  output logic                 result_valid_o,
  output tei_result_t          result_o
);

  // configuration registers
  logic [LR_W-1:0]         lr_q;
  logic signed [VAL_W-1:0] base_q;
  logic [LIM_W-1:0]        lim_q;
  logic [CNT_W-1:0]        count_q;

  // sequencer and datapath registers
  tei_state_e              state_q, state_d;
  logic [TREE_W-1:0]       tree_q, tree_d;
  logic [CNT_W-1:0]        done_q, done_d;
  logic [DEPTH_W-1:0]      depth_q, depth_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    hit_q, hit_d;
  logic                    res_valid_q, res_valid_d;
  tei_result_t             res_q, res_d;

  // memories
  tei_node_t               node_mem [STORE_SIZE];
  logic signed [VAL_W-1:0] feat_mem [NUM_FEATURES];
  tei_node_t               node_q;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;

  // helpers
  logic                    accept;
  logic                    wr_node, wr_feat;
  tei_node_t               wr_entry;
  logic [LR_W-1:0]         lr_eff;
  logic [CNT_W-1:0]        count_eff;
  logic signed [VAL_W:0]   lim_s33;
  logic signed [VAL_W:0]   val_s33;
  logic signed [SUM_W-1:0] lim_wide;
  logic signed [SUM_W-1:0] term;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [VAL_W-1:0] feat_x;
  logic [NODE_W-1:0]       next_node;

  assign accept  = start && !busy;
  assign wr_node = accept && (cmd_i.action == ACT_WRITE_NODE);
  assign wr_feat = accept && (cmd_i.action == ACT_WRITE_FEATURE);
  assign busy    = (state_q != ST_IDLE);

  assign wr_entry.split_feature = cmd_i.split_feature;
  assign wr_entry.leaf_flag     = cmd_i.leaf_flag;
  assign wr_entry.left_node     = cmd_i.left_node;
  assign wr_entry.right_node    = cmd_i.right_node;
  assign wr_entry.threshold     = cmd_i.threshold;
  assign wr_entry.node_value    = cmd_i.node_value;

  // saturate large register values
  assign lr_eff    = (lr_q > LR_ONE) ? LR_ONE : lr_q;
  assign count_eff = (count_q > CNT_W'(MAX_TREES)) ? CNT_W'(MAX_TREES) : count_q;

  assign lim_s33  = $signed({2'b00, lim_q});
  assign val_s33  = {val_q[VAL_W-1], val_q};
  assign lim_wide = $signed({{(SUM_W-LIM_W){1'b0}}, lim_q});

  // round to nearest, halves upward
  assign prod_rnd = prod_q + PROD_W'(32768);
  assign term     = SUM_W'(prod_rnd >>> 16);

  // split decision of the node just read
  assign feat_x    = feat_mem[node_q.split_feature];
  assign next_node = (feat_x <= node_q.threshold) ? node_q.left_node
                                                  : node_q.right_node;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= LR_RESET;
      base_q  <= '0;
      lim_q   <= LIM_RESET;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (tei_cfg_e'(cfg_idx_i))
        CFG_LEARNING_RATE: lr_q    <= cfg_wdata_i[LR_W-1:0];
        CFG_BASE_VALUE:    base_q  <= $signed(cfg_wdata_i);
        CFG_CLIP_LIMIT:    lim_q   <= cfg_wdata_i[LIM_W-1:0];
        CFG_TREE_COUNT:    count_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // node memory, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_node) begin
      node_mem[{cmd_i.tree_slot, cmd_i.node_slot}] <= wr_entry;
    end
    if (rd_en) begin
      node_q <= node_mem[rd_addr];
    end
  end

  // sample features
  always_ff @(posedge clk_i) begin
    if (wr_feat) begin
      feat_mem[cmd_i.feature_slot] <= cmd_i.feature_value;
    end
  end

  // sequencer: next state and datapath
  always_comb begin
    state_d     = state_q;
    tree_d      = tree_q;
    done_d      = done_q;
    depth_d     = depth_q;
    val_d       = val_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    hit_d       = hit_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = {tree_q, next_node};

    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i.action == ACT_EVALUATE)) begin
          sum_d   = SUM_W'(base_q);
          hit_d   = 1'b0;
          tree_d  = '0;
          done_d  = '0;
          depth_d = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = (count_eff == '0) ? ST_FINAL : ST_WALK;
        end
      end
      ST_WALK: begin
        if (node_q.leaf_flag || (depth_q == DEPTH_W'(MAX_WALK_DEPTH))) begin
          val_d   = node_q.node_value;
          state_d = ST_CLIP;
        end else begin
          rd_en   = 1'b1;
          depth_d = depth_q + 1'b1;
        end
      end
      // leaf value clip
      ST_CLIP: begin
        if (val_s33 > lim_s33) begin
          val_d = lim_s33[VAL_W-1:0];
          hit_d = 1'b1;
        end else if (val_s33 < -lim_s33) begin
          val_d = VAL_W'(-lim_s33);
          hit_d = 1'b1;
        end
        state_d = ST_MULT;
      end
      // shrinkage multiply
      ST_MULT: begin
        prod_d  = PROD_W'(val_q * $signed({1'b0, lr_eff}));
        state_d = ST_ACCUM;
      end
      // accumulate and move to the next tree, or to the final clip after the last
      ST_ACCUM: begin
        sum_d   = sum_q + term;
        done_d  = done_q + 1'b1;
        if ((done_q + 1'b1) == count_eff) begin
          state_d = ST_FINAL;
        end else begin
          tree_d  = tree_q + 1'b1;
          depth_d = '0;
          rd_en   = 1'b1;
          rd_addr = {tree_q + 1'b1, NODE_W'(0)};
          state_d = ST_WALK;
        end
      end
      // final clip and result beat
      ST_FINAL: begin
        res_valid_d  = 1'b1;
        res_d.clipped = hit_q;
        res_d.prediction = sum_q[VAL_W-1:0];
        if (sum_q > lim_wide) begin
          res_d.prediction = lim_wide[VAL_W-1:0];
          res_d.clipped    = 1'b1;
        end else if (sum_q < -lim_wide) begin
          res_d.prediction = VAL_W'(-lim_wide);
          res_d.clipped    = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tree_q  <= tree_d;
    done_q  <= done_d;
    depth_q <= depth_d;
    val_q   <= val_d;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
    hit_q   <= hit_d;
    res_q   <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
